// File: hw/rtl/tflt_pkg.sv
`default_nettype none
package tflt_pkg;

  // CORDIC step count, capped by the arctangent table
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int CORDIC_N     = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int IDX_W        = 5;

  // angle constants, Q3.13 and Q29
  localparam logic signed [17:0] PI18      = 18'sd25736;
  localparam logic signed [17:0] TWO_PI18  = 18'sd51472;
  localparam logic signed [32:0] HALF_PI_Z = 33'sd843314857;

  // calibration constants
  localparam logic signed [20:0] ACC_X_K   = 21'sd781115;
  localparam logic signed [37:0] ACC_X_B   = 38'sd10534387;
  localparam logic signed [20:0] ACC_Y_K   = 21'sd904473;
  localparam logic signed [37:0] ACC_Y_B   = 38'sd46575807;
  localparam logic signed [21:0] GYRO_K    = 22'sd1171271;
  localparam logic signed [23:0] GYRO_BIAS = 24'sd35;
  localparam logic signed [25:0] WHEEL_K   = 26'sd26353589;

  // rate*dt scaling: 2000000 = 2^7 * 15625; the 15625 part by reciprocal,
  // ceil(2^43 / 15625), exact for the shifted operand range
  localparam logic [41:0] DIV_HALF  = 42'd1000000;
  localparam logic [41:0] DIV_SAT   = 42'd51474000000;
  localparam logic [29:0] DIV_RECIP = 30'd562949954;

  typedef enum logic [2:0] {
    CFG_TILT_OFFSET  = 3'd0,
    CFG_BLEND_GAIN   = 3'd1,
    CFG_GAIN_ANGLE   = 3'd2,
    CFG_GAIN_TILT    = 3'd3,
    CFG_GAIN_WHEEL   = 3'd4,
    CFG_TORQUE_LIMIT = 3'd5,
    CFG_WHEEL_LIMIT  = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] gyro_z;
    logic [15:0]        elapsed_us;
    logic signed [23:0] wheel_rev_rate;
    logic               wheel_valid;
    logic               stop_request;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] torque_cmd;
    logic signed [15:0] torque_unclamped;
    logic signed [15:0] tilt_angle;
    logic signed [23:0] tilt_rate;
    logic signed [23:0] wheel_rate;
    logic               speed_guarded;
    logic               torque_clamped;
    logic               stopped;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CALC, ST_SETUP, ST_PREP, ST_ITER,
    ST_FIN1, ST_FIN2, ST_FIN3, ST_MUL, ST_SUM, ST_OUT
  } state_t;

  typedef struct packed {
    logic             load;
    logic             calc;
    logic             setup;
    logic             prep;
    logic             step;
    logic             fin1;
    logic             fin2;
    logic             fin3;
    logic             mul;
    logic             sum;
    logic             out_load;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic stopped;
  } status_t;

  // arctangent of 2^-i, Q29
  function automatic logic [29:0] atan_q29(input logic [IDX_W-1:0] i);
    logic [29:0] v;
    unique case (i)
      5'd0:  v = 30'd421657428;
      5'd1:  v = 30'd248918915;
      5'd2:  v = 30'd131521918;
      5'd3:  v = 30'd66762579;
      5'd4:  v = 30'd33510843;
      5'd5:  v = 30'd16771758;
      5'd6:  v = 30'd8387925;
      5'd7:  v = 30'd4194219;
      5'd8:  v = 30'd2097141;
      5'd9:  v = 30'd1048575;
      5'd10: v = 30'd524288;
      5'd11: v = 30'd262144;
      5'd12: v = 30'd131072;
      5'd13: v = 30'd65536;
      5'd14: v = 30'd32768;
      5'd15: v = 30'd16384;
      5'd16: v = 30'd8192;
      5'd17: v = 30'd4096;
      5'd18: v = 30'd2048;
      5'd19: v = 30'd1024;
      5'd20: v = 30'd512;
      5'd21: v = 30'd256;
      5'd22: v = 30'd128;
      5'd23: v = 30'd64;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // one-turn wrap into +-pi; operands never stray more than one turn
  function automatic logic signed [15:0] wrap_pi(input logic signed [17:0] a);
    logic signed [17:0] r;
    r = a;
    if (a > PI18) r = a - TWO_PI18;
    else if (a < -PI18) r = a + TWO_PI18;
    return r[15:0];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/tilt_filter_lqr_torque.sv
// The controller steps from IDLE (tick captured) through CALC, SETUP, PREP,
//   ITER (one iteration per CORDIC step), FIN1-FIN3, MUL, SUM and OUT; a tick
//   taken while the stop latch is set goes from CALC straight to OUT. A new
//   tick is taken only in IDLE, after the last result is loaded for output.
// Synchronous active-high reset restores register defaults, clears the stop
//   latch and held wheel rate, and marks the next tick as the first sample.
`default_nettype none
module tilt_filter_lqr_torque (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire tflt_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output tflt_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_data
);

  tflt_pkg::cmd_t    cmd;
  tflt_pkg::status_t status;

  tflt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  tflt_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// File: hw/rtl/tflt_ctrl.sv
`default_nettype none
module tflt_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  input  wire tflt_pkg::status_t status,
  output tflt_pkg::cmd_t       cmd
);

  tflt_pkg::state_t state, state_next;
  logic [tflt_pkg::IDX_W-1:0] idx, idx_next;

  // state, step counter and output flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tflt_pkg::ST_IDLE;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  assign in_ready = (state == tflt_pkg::ST_IDLE);

  // sequencing
  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    cmd.idx    = idx;
    unique case (state)
      tflt_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = tflt_pkg::ST_CALC;
        end
      end
      tflt_pkg::ST_CALC: begin
        if (status.stopped) begin
          state_next = tflt_pkg::ST_OUT;
        end else begin
          cmd.calc   = 1'b1;
          state_next = tflt_pkg::ST_SETUP;
        end
      end
      tflt_pkg::ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = tflt_pkg::ST_PREP;
      end
      tflt_pkg::ST_PREP: begin
        cmd.prep   = 1'b1;
        idx_next   = '0;
        state_next = tflt_pkg::ST_ITER;
      end
      tflt_pkg::ST_ITER: begin
        cmd.step = 1'b1;
        idx_next = idx + 1'b1;
        if (idx == tflt_pkg::IDX_W'(tflt_pkg::CORDIC_N - 1)) state_next = tflt_pkg::ST_FIN1;
      end
      tflt_pkg::ST_FIN1: begin
        cmd.fin1   = 1'b1;
        state_next = tflt_pkg::ST_FIN2;
      end
      tflt_pkg::ST_FIN2: begin
        cmd.fin2   = 1'b1;
        state_next = tflt_pkg::ST_FIN3;
      end
      tflt_pkg::ST_FIN3: begin
        cmd.fin3   = 1'b1;
        state_next = tflt_pkg::ST_MUL;
      end
      tflt_pkg::ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = tflt_pkg::ST_SUM;
      end
      tflt_pkg::ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = tflt_pkg::ST_OUT;
      end
      tflt_pkg::ST_OUT: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = tflt_pkg::ST_IDLE;
        end
      end
      default: state_next = tflt_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: hw/rtl/tflt_dp.sv
`default_nettype none
module tflt_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire tflt_pkg::in_item_t  in_data,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  input  wire tflt_pkg::cmd_t      cmd,
  output tflt_pkg::status_t        status,
  output tflt_pkg::out_item_t      out_data
);

  // configuration
  logic signed [15:0] tilt_offset;
  logic [15:0]        blend_gain;
  logic signed [31:0] gain_angle, gain_tilt_rate, gain_wheel_rate;
  logic [14:0]        torque_limit;
  logic [22:0]        wheel_speed_limit;

  // persistent state
  logic signed [15:0] prev_tilt;
  logic               first_sample;
  logic               stop_latch;
  logic signed [23:0] held;

  // captured tick
  logic signed [15:0] ax_in, ay_in, gz;
  logic [15:0]        us;
  logic signed [23:0] wr;
  logic               wv;

  // working registers
  logic signed [23:0] rate;
  logic signed [37:0] ax, ay;
  logic signed [40:0] p;
  logic signed [39:0] cx, cy;
  logic signed [32:0] cz;
  logic               zero_vec;
  logic [28:0]        nq;
  logic [14:0]        q;
  logic               neg_p, sat_inc;
  logic signed [15:0] zmeas, pred, theta;
  logic signed [32:0] corr;
  logic signed [47:0] pa;
  logic signed [55:0] pt, pw;
  logic signed [33:0] raw;

  assign status.stopped = stop_latch;

  // calibration products
  logic signed [49:0] wprod;
  logic signed [25:0] wrnd;
  logic signed [23:0] held_next;
  logic signed [37:0] gprod, ax_m, ay_m;
  assign wprod = wr * tflt_pkg::WHEEL_K;
  assign wrnd  = 26'((wprod + 50'sd8388608) >>> 24);
  assign held_next = (wrnd > 26'sd8388607) ? 24'sd8388607 :
                     (wrnd < -26'sd8388608) ? -24'sd8388608 : wrnd[23:0];
  assign gprod = gz * tflt_pkg::GYRO_K;
  assign ax_m  = ax_in * tflt_pkg::ACC_X_K;
  assign ay_m  = ay_in * tflt_pkg::ACC_Y_K;

  // rate*dt product and CORDIC pre-rotation (y = ax, x = ay)
  logic signed [16:0] us_s;
  logic signed [40:0] p_next;
  assign us_s   = signed'({1'b0, us});
  assign p_next = rate * us_s;

  // magnitude plus half divisor, and quotient by reciprocal
  logic signed [40:0] mag;
  logic [41:0]        nd;
  logic [58:0]        qprod;
  assign mag   = p[40] ? -p : p;
  assign nd    = {1'b0, mag} + tflt_pkg::DIV_HALF;
  assign qprod = nq * tflt_pkg::DIV_RECIP;

  // one CORDIC micro-rotation
  logic signed [39:0] dx, dy;
  logic signed [32:0] at;
  assign dx     = cy >>> cmd.idx;
  assign dy     = cx >>> cmd.idx;
  assign at     = signed'({3'b0, tflt_pkg::atan_q29(cmd.idx)});

  // measured angle and prediction
  logic signed [32:0] zr_full;
  logic signed [16:0] zr, zsat;
  logic signed [15:0] inc, cord;
  assign zr_full = cz + 33'sd32768;
  assign zr      = 17'(zr_full >>> 16);
  assign zsat    = (zr > 17'sd25736) ? 17'sd25736 : (zr < -17'sd25736) ? -17'sd25736 : zr;
  assign cord    = zero_vec ? 16'sd0 : zsat[15:0];
  assign inc     = sat_inc ? (neg_p ? -16'sd25736 : 16'sd25736)
                           : (neg_p ? -signed'({1'b0, q}) : signed'({1'b0, q}));

  // correction
  logic signed [15:0] err;
  logic signed [16:0] bg_s, crnd;
  assign err  = tflt_pkg::wrap_pi(18'(zmeas) - 18'(pred));
  assign bg_s = signed'({1'b0, blend_gain});
  assign crnd = 17'((corr + 33'sd32768) >>> 16);

  // LQR sum
  logic signed [57:0] lsum;
  assign lsum = {{9{pa[47]}}, pa, 1'b0} + 58'(pt) + 58'(pw);

  // clamp and speed guard
  logic signed [33:0] lim_s;
  logic signed [15:0] tq, tq_c;
  logic               clamped, guarded;
  logic signed [24:0] held25, wl25;
  assign lim_s  = signed'({19'd0, torque_limit});
  assign held25 = 25'(held);
  assign wl25   = signed'({2'b0, wheel_speed_limit});
  always_comb begin
    clamped = 1'b0;
    tq_c    = raw[15:0];
    if (raw > lim_s) begin
      tq_c    = signed'({1'b0, torque_limit});
      clamped = 1'b1;
    end else if (raw < -lim_s) begin
      tq_c    = -signed'({1'b0, torque_limit});
      clamped = 1'b1;
    end
    guarded = (held25 >= wl25 && tq_c > 16'sd0) || (held25 <= -wl25 && tq_c < 16'sd0);
    tq      = guarded ? 16'sd0 : tq_c;
  end

  // configuration and persistent state
  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_offset       <= 16'sd0;
      blend_gain        <= 16'd2621;
      gain_angle        <= -32'sd60335902;
      gain_tilt_rate    <= -32'sd3534959;
      gain_wheel_rate   <= -32'sd11623;
      torque_limit      <= 15'd1024;
      wheel_speed_limit <= 23'd3276800;
      prev_tilt         <= 16'sd0;
      first_sample      <= 1'b1;
      stop_latch        <= 1'b0;
      held              <= 24'sd0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tflt_pkg::CFG_TILT_OFFSET:  tilt_offset       <= cfg_data[15:0];
          tflt_pkg::CFG_BLEND_GAIN:   blend_gain        <= cfg_data[15:0];
          tflt_pkg::CFG_GAIN_ANGLE:   gain_angle        <= cfg_data;
          tflt_pkg::CFG_GAIN_TILT:    gain_tilt_rate    <= cfg_data;
          tflt_pkg::CFG_GAIN_WHEEL:   gain_wheel_rate   <= cfg_data;
          tflt_pkg::CFG_TORQUE_LIMIT: torque_limit      <= cfg_data[14:0];
          tflt_pkg::CFG_WHEEL_LIMIT:  wheel_speed_limit <= cfg_data[22:0];
          default: ;
        endcase
      end
      if (cmd.load && in_data.stop_request) stop_latch <= 1'b1;
      if (cmd.calc && wv) held <= held_next;
      // theta is settled by the multiply step
      if (cmd.mul) begin
        prev_tilt    <= theta;
        first_sample <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax_in <= in_data.accel_x;
      ay_in <= in_data.accel_y;
      gz    <= in_data.gyro_z;
      us    <= in_data.elapsed_us;
      wr    <= in_data.wheel_rev_rate;
      wv    <= in_data.wheel_valid;
    end
    if (cmd.calc) begin
      rate <= 24'((gprod + 38'sd32768) >>> 16) + tflt_pkg::GYRO_BIAS;
      ax   <= ax_m - tflt_pkg::ACC_X_B;
      ay   <= ay_m + tflt_pkg::ACC_Y_B;
    end
    if (cmd.setup) begin
      p        <= p_next;
      zero_vec <= (ax == 38'sd0) && (ay == 38'sd0);
      if (ay < 38'sd0) begin
        if (ax >= 38'sd0) begin
          cx <= 40'(ax);
          cy <= -40'(ay);
          cz <= tflt_pkg::HALF_PI_Z;
        end else begin
          cx <= -40'(ax);
          cy <= 40'(ay);
          cz <= -tflt_pkg::HALF_PI_Z;
        end
      end else begin
        cx <= 40'(ay);
        cy <= 40'(ax);
        cz <= 33'sd0;
      end
    end
    if (cmd.prep) begin
      neg_p   <= p[40];
      sat_inc <= nd >= tflt_pkg::DIV_SAT;
      nq      <= nd[35:7];
    end
    if (cmd.step) begin
      if (cy >= 40'sd0) begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + at;
      end else begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - at;
      end
      // quotient of the rate*dt term, taken on the first step
      if (cmd.idx == '0) q <= qprod[57:43];
    end
    if (cmd.fin1) begin
      zmeas <= tflt_pkg::wrap_pi(18'(cord) - 18'(tilt_offset));
      pred  <= tflt_pkg::wrap_pi(18'(prev_tilt) + 18'(inc));
    end
    if (cmd.fin2) corr <= err * bg_s;
    if (cmd.fin3) theta <= first_sample ? zmeas : tflt_pkg::wrap_pi(18'(pred) + 18'(crnd));
    if (cmd.mul) begin
      pa <= gain_angle * theta;
      pt <= gain_tilt_rate * rate;
      pw <= gain_wheel_rate * held;
    end
    if (cmd.sum) raw <= 34'((lsum + 58'sd33554432) >>> 26);
    if (cmd.out_load) begin
      if (stop_latch) begin
        out_data.torque_cmd       <= 16'sd0;
        out_data.torque_unclamped <= 16'sd0;
        out_data.tilt_angle       <= prev_tilt;
        out_data.tilt_rate        <= 24'sd0;
        out_data.wheel_rate       <= held;
        out_data.speed_guarded    <= 1'b0;
        out_data.torque_clamped   <= 1'b0;
        out_data.stopped          <= 1'b1;
      end else begin
        out_data.torque_cmd       <= tq;
        out_data.torque_unclamped <= (raw > 34'sd32767) ? 16'sd32767 :
                                     (raw < -34'sd32768) ? -16'sd32768 : raw[15:0];
        out_data.tilt_angle       <= theta;
        out_data.tilt_rate        <= rate;
        out_data.wheel_rate       <= held;
        out_data.speed_guarded    <= guarded;
        out_data.torque_clamped   <= clamped;
        out_data.stopped          <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: tb/tilt_filter_lqr_torque_tb.sv
`timescale 1ns / 1ps
module tilt_filter_lqr_torque_tb;

  localparam longint PI_A  = 25736;
  localparam longint TURN  = 51472;
  localparam longint HALFZ = 843314857;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  tflt_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  tflt_pkg::out_item_t out_data;
  logic                cfg_we;
  logic [2:0]          cfg_index;
  logic [31:0]         cfg_data;

  tilt_filter_lqr_torque i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of registers and state
  logic signed [15:0] offs_r;
  logic [15:0]        blend_r;
  logic signed [31:0] k_ang_r, k_tilt_r, k_wheel_r;
  logic [14:0]        tq_lim_r;
  logic [22:0]        wh_lim_r;
  longint             last_tilt;
  bit                 first_tick;
  bit                 estop;
  longint             held_rate;

  tflt_pkg::out_item_t expected_q[$];
  int        n_errors;
  bit        long_hold;

  longint atan_tab[24] = '{
    421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
    8387925, 4194219, 2097141, 1048575, 524288, 262144,
    131072, 65536, 32768, 16384, 8192, 4096,
    2048, 1024, 512, 256, 128, 64};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint wrap_turn(longint a);
    while (a > PI_A) a -= TURN;
    while (a < -PI_A) a += TURN;
    return a;
  endfunction

  // vectoring atan2(y, x), Q3.13
  function automatic longint atan2_q13(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HALFZ;
      end else begin
        x = -y; y = t; z = -HALFZ;
      end
    end
    for (int i = 0; i < tflt_pkg::CORDIC_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_tab[i];
      end else begin
        x -= dx; y += dy; z -= atan_tab[i];
      end
    end
    return clip(round_shift(z, 16), -PI_A, PI_A);
  endfunction

  function automatic tflt_pkg::out_item_t predict_tick(tflt_pkg::in_item_t it);
    tflt_pkg::out_item_t r;
    longint rate, ax, ay, meas, theta, raw, tq, p, mag, inc, pred, err;
    r = '0;
    if (it.stop_request) estop = 1'b1;
    if (estop) begin
      r.tilt_angle = last_tilt[15:0];
      r.wheel_rate = held_rate[23:0];
      r.stopped    = 1'b1;
      return r;
    end
    if (it.wheel_valid)
      held_rate = clip(round_shift(longint'(it.wheel_rev_rate) * 26353589, 24),
                       -8388608, 8388607);
    rate = round_shift(longint'(it.gyro_z) * 1171271, 16) + 35;
    ax = longint'(it.accel_x) * 781115 - 10534387;
    ay = longint'(it.accel_y) * 904473 + 46575807;
    meas = wrap_turn(atan2_q13(ax, ay) - longint'(offs_r));
    if (first_tick) begin
      theta = meas;
      first_tick = 1'b0;
    end else begin
      p = rate * longint'(it.elapsed_us);
      mag = p < 0 ? -p : p;
      inc = (mag + 1000000) / 2000000;
      if (p < 0) inc = -inc;
      inc = clip(inc, -PI_A, PI_A);
      pred = wrap_turn(last_tilt + inc);
      err = wrap_turn(meas - pred);
      theta = wrap_turn(pred + round_shift(err * longint'(blend_r), 16));
    end
    last_tilt = theta;
    raw = round_shift(longint'(k_ang_r) * theta * 2 + longint'(k_tilt_r) * rate
                      + longint'(k_wheel_r) * held_rate, 26);
    tq = raw;
    if (raw > longint'(tq_lim_r)) begin
      tq = tq_lim_r; r.torque_clamped = 1'b1;
    end else if (raw < -longint'(tq_lim_r)) begin
      tq = -longint'(tq_lim_r); r.torque_clamped = 1'b1;
    end
    if ((held_rate >= longint'(wh_lim_r) && tq > 0) ||
        (held_rate <= -longint'(wh_lim_r) && tq < 0)) begin
      tq = 0; r.speed_guarded = 1'b1;
    end
    r.torque_cmd       = tq[15:0];
    r.torque_unclamped = 16'(clip(raw, -32768, 32767));
    r.tilt_angle       = theta[15:0];
    r.tilt_rate        = rate[23:0];
    r.wheel_rate       = held_rate[23:0];
    return r;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    tflt_pkg::out_item_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected: %h", $time, out_data);
        n_errors++;
      end else begin
        e = expected_q.pop_front();
        check_field("torque_cmd", e.torque_cmd, out_data.torque_cmd);
        check_field("torque_unclamped", e.torque_unclamped, out_data.torque_unclamped);
        check_field("tilt_angle", e.tilt_angle, out_data.tilt_angle);
        check_field("tilt_rate", e.tilt_rate, out_data.tilt_rate);
        check_field("wheel_rate", e.wheel_rate, out_data.wheel_rate);
        check_field("speed_guarded", e.speed_guarded, out_data.speed_guarded);
        check_field("torque_clamped", e.torque_clamped, out_data.torque_clamped);
        check_field("stopped", e.stopped, out_data.stopped);
      end
    end
  end

  // receiver: changing stall mode, plus one long hold-off on request
  initial begin
    int mode, left;
    out_ready <= 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(50, 300);
      end
      left--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send_tick(tflt_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_q.push_back(predict_tick(it));
  endtask

  task automatic pause(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(tflt_pkg::cfg_reg_e idx, logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    case (idx)
      tflt_pkg::CFG_TILT_OFFSET:  offs_r    = v[15:0];
      tflt_pkg::CFG_BLEND_GAIN:   blend_r   = v[15:0];
      tflt_pkg::CFG_GAIN_ANGLE:   k_ang_r   = v;
      tflt_pkg::CFG_GAIN_TILT:    k_tilt_r  = v;
      tflt_pkg::CFG_GAIN_WHEEL:   k_wheel_r = v;
      tflt_pkg::CFG_TORQUE_LIMIT: tq_lim_r  = v[14:0];
      tflt_pkg::CFG_WHEEL_LIMIT:  wh_lim_r  = v[22:0];
      default: ;
    endcase
  endtask

  task automatic load_settings(logic [31:0] offs, logic [31:0] blend, logic [31:0] ka,
                               logic [31:0] kt, logic [31:0] kw, logic [31:0] tl,
                               logic [31:0] wl);
    write_reg(tflt_pkg::CFG_TILT_OFFSET, offs);
    write_reg(tflt_pkg::CFG_BLEND_GAIN, blend);
    write_reg(tflt_pkg::CFG_GAIN_ANGLE, ka);
    write_reg(tflt_pkg::CFG_GAIN_TILT, kt);
    write_reg(tflt_pkg::CFG_GAIN_WHEEL, kw);
    write_reg(tflt_pkg::CFG_TORQUE_LIMIT, tl);
    write_reg(tflt_pkg::CFG_WHEEL_LIMIT, wl);
    cfg_we <= 1'b0;
  endtask

  function automatic tflt_pkg::in_item_t make_tick(logic signed [15:0] ax,
                                                   logic signed [15:0] ay,
                                                   logic signed [15:0] gz, logic [15:0] us,
                                                   logic signed [23:0] wr, bit wv, bit stp);
    tflt_pkg::in_item_t it;
    it.accel_x = ax; it.accel_y = ay; it.gyro_z = gz; it.elapsed_us = us;
    it.wheel_rev_rate = wr; it.wheel_valid = wv; it.stop_request = stp;
    return it;
  endfunction

  function automatic tflt_pkg::in_item_t random_tick();
    tflt_pkg::in_item_t it;
    it = '0;
    it.accel_x = 16'($urandom);
    it.accel_y = 16'($urandom);
    it.gyro_z = 16'($urandom);
    it.wheel_rev_rate = 24'($urandom);
    if ($urandom_range(0, 1)) begin
      // near upright, small motion
      it.accel_x = 16'($signed(16'($urandom_range(0, 1200))) - 600);
      it.accel_y = $signed(16'($urandom_range(3600, 4600)));
      it.gyro_z  = 16'($signed(16'($urandom_range(0, 4000))) - 2000);
      it.wheel_rev_rate = 24'($signed(24'($urandom_range(0, 1600000))) - 800000);
    end
    it.elapsed_us = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(800, 1200));
    it.wheel_valid  = 1'($urandom_range(0, 1));
    it.stop_request = 1'b0;
    return it;
  endfunction

  // ---------------------------------------------------------------- tests
  // first tick after reset takes the measurement directly; then field extremes
  task automatic test_directed_extremes();
    send_tick(make_tick(16'sd0, 16'sd4096, 16'sd0, 16'hFFFF, 24'sd0, 1'b0, 1'b0));
    send_tick(make_tick(-16'sd32768, -16'sd32768, 16'sd0, 16'd1000, 24'sd0, 1'b1, 1'b0));
    send_tick(make_tick(16'sd32767, 16'sd32767, 16'sd0, 16'd1000, 24'sd0, 1'b0, 1'b0));
    send_tick(make_tick(16'sd32767, -16'sd32768, 16'sd32767, 16'hFFFF, 24'sd0, 1'b0, 1'b0));
    send_tick(make_tick(-16'sd32768, 16'sd32767, -16'sd32768, 16'hFFFF, 24'sd0, 1'b0, 1'b0));
    send_tick(make_tick(16'sd0, -16'sd4096, -16'sd32768, 16'd0, 24'sh7FFFFF, 1'b1, 1'b0));
    send_tick(make_tick(16'sd4096, 16'sd0, 16'sd100, 16'd1, 24'sh800000, 1'b1, 1'b0));
    send_tick(make_tick(-16'sd4096, 16'sd0, 16'sd100, 16'd1000, 24'sh7FFFFF, 1'b0, 1'b0));
    send_tick(make_tick(16'sd0, 16'sd0, -16'sd1, 16'd1000, 24'sd0, 1'b0, 1'b0));
    send_tick(make_tick(16'sd14, -16'sd52, 16'sd0, 16'd1000, 24'sh555555, 1'b1, 1'b0));
    send_tick(make_tick(16'sd0, 16'sd4096, 16'sd0, 16'd1000, 24'shAAAAAA, 1'b1, 1'b0));
    wait_drained();
  endtask

  // register extremes, including offsets beyond half a turn
  task automatic test_register_extremes();
    load_settings(32'h7FFF, 32'd0, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'd0, 32'd0);
    repeat (6) send_tick(random_tick());
    wait_drained();
    load_settings(32'hFFFF8000, 32'hFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                  32'h7FFF, 32'h7FFFFF);
    repeat (6) send_tick(random_tick());
    wait_drained();
  endtask

  // bursty random ticks over several settings
  task automatic test_random_phases(int total);
    int sent, burst;
    sent = 0;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: load_settings(32'd0, 32'd2621, -32'sd60335902, -32'sd3534959, -32'sd11623,
                         32'd1024, 32'd3276800);
        1: load_settings(32'($signed(16'($urandom_range(0, 51472)) - 25736)),
                         $urandom_range(0, 65535), -32'sd60335902, -32'sd3534959,
                         -32'sd11623, $urandom_range(0, 32767), $urandom_range(0, 8388607));
        2: load_settings($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        default: load_settings(32'd0, 32'd65535, -32'sd6033590, -32'sd353495, -32'sd1162,
                               32'd32767, 32'd100000);
      endcase
      while (sent < total * (ph + 1) / 8) begin
        burst = $urandom_range(1, 20);
        repeat (burst) begin
          send_tick(random_tick());
          sent++;
        end
        pause($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15));
      end
      wait_drained();
    end
  endtask

  // receiver holds off while ticks keep coming, so the input stalls
  task automatic test_output_backpressure();
    long_hold = 1'b1;
    repeat (12) send_tick(random_tick());
    wait_drained();
  endtask

  // stop latches for good: must run last
  task automatic test_stop_latch();
    tflt_pkg::in_item_t it;
    send_tick(random_tick());
    it = random_tick();
    it.stop_request = 1'b1;
    it.wheel_valid = 1'b1;
    send_tick(it);
    repeat (5) send_tick(random_tick());
    it = random_tick();
    it.stop_request = 1'b1;
    send_tick(it);
    wait_drained();
  endtask

  initial begin
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= tflt_pkg::CFG_TILT_OFFSET;
    cfg_data  <= '0;
    n_errors  = 0;
    long_hold = 1'b0;
    offs_r = 0; blend_r = 2621; k_ang_r = -32'sd60335902; k_tilt_r = -32'sd3534959;
    k_wheel_r = -32'sd11623; tq_lim_r = 1024; wh_lim_r = 3276800;
    last_tilt = 0; first_tick = 1'b1; estop = 1'b0; held_rate = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_register_extremes();
    test_random_phases(2000);
    test_output_backpressure();
    test_stop_latch();
    if (n_errors == 0)
      $display("tilt_filter_lqr_torque_tb: done, clean");
    else
      $display("tilt_filter_lqr_torque_tb: done, errors");
    $finish;
  end

  initial begin
    #5ms;
    $display("tilt_filter_lqr_torque_tb: done, errors");
    $finish;
  end

endmodule
